[design/generational_entity_table_core_defines.svh]
// assertion macros for the generational entity table
`ifndef GENERATIONAL_ENTITY_TABLE_CORE_DEFINES_SVH
`define GENERATIONAL_ENTITY_TABLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// checked property, held off while reset is asserted
`define GENT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked property, also sampled during reset
`define GENT_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define GENT_ASSERT(lbl, prop, msg)
`define GENT_ASSERT_NR(lbl, prop, msg)
`endif

`endif

[design/gent_pkg.sv]
// shared types and constants of the generational entity table
package gent_pkg;

  // fixed field widths
  localparam int ACT_W  = 3;
  localparam int IDX_W  = 10;
  localparam int GEN_W  = 8;
  localparam int KIND_W = 4;
  localparam int MASK_W = 14;
  localparam int CNT_W  = 11;

  // built table depth and component kinds
  localparam int ENTITY_SLOTS_DEF = 1024;
  localparam int COMPONENT_KINDS  = 14;

  // reset value of the slot limit register
  localparam logic [CNT_W-1:0] LIMIT_RST = CNT_W'(1024);

  // component numbers below this are accepted
  localparam logic [KIND_W:0] KIND_LIMIT = (KIND_W + 1)'(COMPONENT_KINDS);

  // mask bits that take part in a query
  localparam logic [MASK_W-1:0] KIND_MASK = (COMPONENT_KINDS >= MASK_W) ? '1 :
                                            MASK_W'((64'd1 << COMPONENT_KINDS) - 64'd1);

  // request codes
  typedef enum logic [ACT_W-1:0] {
    ACT_SPAWN   = 3'd0,
    ACT_DESPAWN = 3'd1,
    ACT_ALIVE   = 3'd2,
    ACT_ADD     = 3'd3,
    ACT_REMOVE  = 3'd4,
    ACT_HAS     = 3'd5,
    ACT_QRESET  = 3'd6,
    ACT_QNEXT   = 3'd7
  } action_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ISSUE,
    S_POP,
    S_EXEC,
    S_CHECK,
    S_RESP
  } state_e;

  // one slot of the entity memory
  typedef struct packed {
    logic [GEN_W-1:0]  gen;
    logic [MASK_W-1:0] mask;
  } entry_t;

endpackage

[design/gent_ram.sv]
// generic single write, single read memory with registered read data
module gent_ram #(
  parameter int WIDTH = gent_pkg::GEN_W + gent_pkg::MASK_W,
  parameter int DEPTH = gent_pkg::ENTITY_SLOTS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/generational_entity_table_core.sv]
// Entity table with generational handles (index plus 8-bit generation). Per-slot generation
// and component mask sit in one memory, the LIFO free list in a second; each has one write
// and one registered read port, so a request on a slot walks a read, modify and write-back
// sequence, and a new request is taken only once the sequencer is idle again. A spawn pops
// the free list first when it is not empty, else takes a fresh slot; query next reads one
// slot of the entity memory per cycle until a match or the last fresh slot. After reset the
// entity memory is swept to zero, one slot per cycle, over all ENTITY_SLOTS slots (1024 by
// default); requests are stalled during that sweep while limit writes are taken as usual.
// The result register lets a new request enter while the previous result still waits
// downstream.
`include "generational_entity_table_core_defines.svh"

module generational_entity_table_core #(
  parameter int ENTITY_SLOTS = gent_pkg::ENTITY_SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // limit register write
  input  logic                          cfg_we_i,
  input  logic [gent_pkg::CNT_W-1:0]    cfg_wdata_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [gent_pkg::ACT_W-1:0]    action_i,
  input  logic [gent_pkg::IDX_W-1:0]    entity_index_i,
  input  logic [gent_pkg::GEN_W-1:0]    entity_generation_i,
  input  logic [gent_pkg::KIND_W-1:0]   component_type_i,
  input  logic [gent_pkg::MASK_W-1:0]   required_mask_i,
  input  logic [gent_pkg::MASK_W-1:0]   excluded_mask_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          ok_o,
  output logic [gent_pkg::IDX_W-1:0]    out_index_o,
  output logic [gent_pkg::GEN_W-1:0]    out_generation_o,
  output logic [gent_pkg::CNT_W-1:0]    live_count_o
);

  localparam int AW = $clog2(ENTITY_SLOTS);
  localparam int SW = $clog2(ENTITY_SLOTS + 1);
  localparam int LW = (SW > gent_pkg::CNT_W) ? SW : gent_pkg::CNT_W;
  localparam logic [AW-1:0] LAST_SLOT = AW'(ENTITY_SLOTS - 1);
  localparam logic [SW-1:0] SLOTS_S   = SW'(ENTITY_SLOTS);
  localparam logic [LW-1:0] SLOTS_L   = LW'(ENTITY_SLOTS);
  localparam int EW = $bits(gent_pkg::entry_t);

  gent_pkg::state_e state_q, state_d;

  // latched request
  gent_pkg::action_e                act_q;
  logic [gent_pkg::IDX_W-1:0]       idx_q;
  logic [gent_pkg::GEN_W-1:0]       gen_q;
  logic [gent_pkg::KIND_W-1:0]      kind_q;
  logic [gent_pkg::MASK_W-1:0]      reqm_q;
  logic [gent_pkg::MASK_W-1:0]      excm_q;

  // table control state
  logic [AW-1:0]                    clr_q, clr_d;
  logic [AW-1:0]                    slot_q, slot_d;
  logic [SW-1:0]                    free_depth_q, free_depth_d;
  logic [SW-1:0]                    fresh_q, fresh_d;
  logic [SW-1:0]                    total_q, total_d;
  logic [SW-1:0]                    cursor_q, cursor_d;
  logic [gent_pkg::CNT_W-1:0]       limit_q;

  // pending result
  logic                             res_ok_q, res_ok_d;
  logic [gent_pkg::IDX_W-1:0]       res_idx_q, res_idx_d;
  logic [gent_pkg::GEN_W-1:0]       res_gen_q, res_gen_d;

  // output register
  logic                             out_valid_q;
  logic                             out_ok_q;
  logic [gent_pkg::IDX_W-1:0]       out_idx_q;
  logic [gent_pkg::GEN_W-1:0]       out_gen_q;
  logic [gent_pkg::CNT_W-1:0]       out_live_q;
  logic                             out_load;

  // memory ports
  logic                             ent_we;
  logic [AW-1:0]                    ent_waddr;
  gent_pkg::entry_t                 ent_wdata;
  logic [AW-1:0]                    ent_raddr;
  gent_pkg::entry_t                 ent_rd;
  logic                             stk_we;
  logic [AW-1:0]                    stk_waddr;
  logic [AW-1:0]                    stk_wdata;
  logic [AW-1:0]                    stk_raddr;
  logic [AW-1:0]                    stk_rdata;

  // derived conditions
  logic [LW-1:0]                    lim_ext;
  logic [LW-1:0]                    eff_limit;
  logic                             alive;
  logic                             kind_ok;
  logic [gent_pkg::MASK_W-1:0]      kind_bit;
  logic [gent_pkg::MASK_W-1:0]      req_eff;
  logic [gent_pkg::MASK_W-1:0]      exc_eff;
  logic                             match;
  logic                             cursor_more;
  logic                             stack_room;

  // entity memory: generation and component mask per slot
  gent_ram #(
    .WIDTH (EW),
    .DEPTH (ENTITY_SLOTS)
  ) u_entity_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rd)
  );

  // free list memory
  gent_ram #(
    .WIDTH (AW),
    .DEPTH (ENTITY_SLOTS)
  ) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // effective limit and handle checks
  assign lim_ext     = LW'(limit_q);
  assign eff_limit   = (lim_ext < SLOTS_L) ? lim_ext : SLOTS_L;
  assign alive       = (LW'(idx_q) < eff_limit) && (gen_q == ent_rd.gen);
  assign kind_ok     = {1'b0, kind_q} < gent_pkg::KIND_LIMIT;
  assign kind_bit    = kind_ok ? (gent_pkg::MASK_W'(1) << kind_q) : '0;
  assign stack_room  = free_depth_q < SLOTS_S;
  assign cursor_more = cursor_q < fresh_q;

  // query match on the slot read last cycle
  assign req_eff = reqm_q & gent_pkg::KIND_MASK;
  assign exc_eff = excm_q & gent_pkg::KIND_MASK;
  assign match   = (slot_q != '0) && (ent_rd.mask != '0) &&
                   ((ent_rd.mask & req_eff) == req_eff) &&
                   ((ent_rd.mask & exc_eff) == '0);

  assign in_stall_o = (state_q != gent_pkg::S_IDLE);

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= gent_pkg::S_CLEAR;
      clr_q        <= '0;
      free_depth_q <= '0;
      fresh_q      <= SW'(1);
      total_q      <= '0;
      cursor_q     <= '0;
      limit_q      <= gent_pkg::LIMIT_RST;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      free_depth_q <= free_depth_d;
      fresh_q      <= fresh_d;
      total_q      <= total_d;
      cursor_q     <= cursor_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request capture, working registers and result payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      act_q  <= gent_pkg::action_e'(action_i);
      idx_q  <= entity_index_i;
      gen_q  <= entity_generation_i;
      kind_q <= component_type_i;
      reqm_q <= required_mask_i;
      excm_q <= excluded_mask_i;
    end
    slot_q    <= slot_d;
    res_ok_q  <= res_ok_d;
    res_idx_q <= res_idx_d;
    res_gen_q <= res_gen_d;
    if (out_load) begin
      out_ok_q   <= res_ok_q;
      out_idx_q  <= res_idx_q;
      out_gen_q  <= res_gen_q;
      out_live_q <= gent_pkg::CNT_W'(total_q);
    end
  end

  // sequencer: next state, memory accesses and state updates
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    slot_d       = slot_q;
    free_depth_d = free_depth_q;
    fresh_d      = fresh_q;
    total_d      = total_q;
    cursor_d     = cursor_q;
    res_ok_d     = res_ok_q;
    res_idx_d    = res_idx_q;
    res_gen_d    = res_gen_q;
    out_load     = 1'b0;
    ent_we       = 1'b0;
    ent_waddr    = slot_q;
    ent_wdata    = '0;
    ent_raddr    = slot_q;
    stk_we       = 1'b0;
    stk_waddr    = AW'(free_depth_q);
    stk_wdata    = AW'(idx_q);
    stk_raddr    = AW'(free_depth_q - SW'(1));

    unique case (state_q)
      // sweep the entity memory to zero after reset
      gent_pkg::S_CLEAR: begin
        ent_we    = 1'b1;
        ent_waddr = clr_q;
        if (clr_q == LAST_SLOT) begin
          state_d = gent_pkg::S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end

      gent_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = gent_pkg::S_ISSUE;
        end
      end

      // issue the first memory read of the request
      gent_pkg::S_ISSUE: begin
        res_ok_d  = 1'b0;
        res_idx_d = '0;
        res_gen_d = '0;
        unique case (act_q)
          gent_pkg::ACT_SPAWN: begin
            if (free_depth_q != '0) begin
              free_depth_d = free_depth_q - SW'(1);
              state_d      = gent_pkg::S_POP;
            end else if (LW'(fresh_q) < eff_limit) begin
              ent_raddr = AW'(fresh_q);
              slot_d    = AW'(fresh_q);
              fresh_d   = fresh_q + SW'(1);
              state_d   = gent_pkg::S_EXEC;
            end else begin
              state_d = gent_pkg::S_RESP;
            end
          end
          gent_pkg::ACT_QRESET: begin
            cursor_d = '0;
            res_ok_d = 1'b1;
            state_d  = gent_pkg::S_RESP;
          end
          gent_pkg::ACT_QNEXT: begin
            if (cursor_more) begin
              ent_raddr = AW'(cursor_q);
              slot_d    = AW'(cursor_q);
              cursor_d  = cursor_q + SW'(1);
              state_d   = gent_pkg::S_CHECK;
            end else begin
              state_d = gent_pkg::S_RESP;
            end
          end
          default: begin
            ent_raddr = AW'(idx_q);
            slot_d    = AW'(idx_q);
            state_d   = gent_pkg::S_EXEC;
          end
        endcase
      end

      // popped slot arrives from the free list
      gent_pkg::S_POP: begin
        slot_d    = stk_rdata;
        ent_raddr = stk_rdata;
        state_d   = gent_pkg::S_EXEC;
      end

      // modify the slot entry and write it back where the request changes it
      gent_pkg::S_EXEC: begin
        state_d = gent_pkg::S_RESP;
        unique case (act_q)
          gent_pkg::ACT_SPAWN: begin
            ent_we         = 1'b1;
            ent_wdata.gen  = ent_rd.gen;
            ent_wdata.mask = '0;
            total_d        = total_q + SW'(1);
            res_ok_d       = 1'b1;
            res_idx_d      = gent_pkg::IDX_W'(slot_q);
            res_gen_d      = ent_rd.gen;
          end
          gent_pkg::ACT_DESPAWN: begin
            if (alive && (total_q != '0) && stack_room) begin
              ent_we         = 1'b1;
              ent_wdata.gen  = ent_rd.gen + gent_pkg::GEN_W'(1);
              ent_wdata.mask = '0;
              stk_we         = 1'b1;
              free_depth_d   = free_depth_q + SW'(1);
              total_d        = total_q - SW'(1);
              res_ok_d       = 1'b1;
            end
          end
          gent_pkg::ACT_ALIVE: begin
            res_ok_d = alive;
          end
          gent_pkg::ACT_ADD: begin
            if (kind_ok && alive) begin
              ent_we         = 1'b1;
              ent_wdata.gen  = ent_rd.gen;
              ent_wdata.mask = ent_rd.mask | kind_bit;
              res_ok_d       = 1'b1;
            end
          end
          gent_pkg::ACT_REMOVE: begin
            if (kind_ok && alive) begin
              ent_we         = 1'b1;
              ent_wdata.gen  = ent_rd.gen;
              ent_wdata.mask = ent_rd.mask & ~kind_bit;
              res_ok_d       = 1'b1;
            end
          end
          gent_pkg::ACT_HAS: begin
            res_ok_d = kind_ok && alive && ((ent_rd.mask & kind_bit) != '0);
          end
          default: begin
            res_ok_d = 1'b0;
          end
        endcase
      end

      // query scan, one slot per cycle
      gent_pkg::S_CHECK: begin
        if (match) begin
          res_ok_d  = 1'b1;
          res_idx_d = gent_pkg::IDX_W'(slot_q);
          res_gen_d = ent_rd.gen;
          state_d   = gent_pkg::S_RESP;
        end else if (cursor_more) begin
          ent_raddr = AW'(cursor_q);
          slot_d    = AW'(cursor_q);
          cursor_d  = cursor_q + SW'(1);
        end else begin
          state_d = gent_pkg::S_RESP;
        end
      end

      // hand the result to the output register once it is free
      gent_pkg::S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = gent_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = gent_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign ok_o             = out_ok_q;
  assign out_index_o      = out_idx_q;
  assign out_generation_o = out_gen_q;
  assign live_count_o     = out_live_q;

  // entity memory is written only by the sweep or the write-back step
  `GENT_ASSERT(a_ent_write_phase,
    ent_we |-> (state_q == gent_pkg::S_CLEAR || state_q == gent_pkg::S_EXEC),
    "entity memory written outside sweep or write-back")
  // a push never runs past the free list depth
  `GENT_ASSERT(a_push_room, stk_we |-> (free_depth_q < SLOTS_S), "free list overflow")
  // the scan cursor never passes the fresh slot mark
  `GENT_ASSERT(a_cursor_bound, cursor_q <= fresh_q, "scan cursor beyond fresh slots")
  // a loaded result always returns the sequencer to idle
  `GENT_ASSERT(a_load_idle, out_load |=> (state_q == gent_pkg::S_IDLE),
    "result loaded without returning to idle")

endmodule
